[src/tdsu_pkg.sv]
// Shared types, constants and helpers of the TDC subevent word unpacker.
package tdsu_pkg;

  // Word marks in bits 31..29
  localparam logic [2:0] HEADER_MARK = 3'd1;
  localparam logic [2:0] DEBUG_MARK  = 3'd2;
  localparam logic [2:0] EPOCH_MARK  = 3'd3;

  localparam int ADDRESS_SLOTS = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_HUB_LIST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUB_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TDC_LIST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TDC_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CTS_ADDR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_CHAN  = 3'd5;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Result kinds
  localparam logic KIND_HIT    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [63:0] hub_list;
    logic [2:0]  hub_count;
    logic [63:0] tdc_list;
    logic [2:0]  tdc_count;
    logic [6:0]  ref_channel;
  } tdsu_cfg_t;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] endpoint_address;
    logic [6:0]  channel;
    logic [7:0]  random_bits;
    logic [15:0] header_error_bits;
    logic        edge_res;
    logic [27:0] epoch;
    logic [10:0] coarse_time;
    logic [9:0]  fine_time;
    logic        is_reference;
    logic        bad_header_seen;
    logic        skip_overrun;
  } tdsu_result_t;

  // One decoded word: an optional hit followed by an optional status
  typedef struct packed {
    logic         has_hit;
    logic         has_status;
    tdsu_result_t hit;
    logic         bad_header_seen;
    logic         skip_overrun;
  } tdsu_entry_t;

  // Address lookup over the first count entries; counts above the slot count saturate
  function automatic logic addr_in_list(logic [63:0] list, logic [2:0] count,
                                        logic [15:0] addr);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < ADDRESS_SLOTS; k++) begin
      if ((3'(k) < count) && (list[16*k +: 16] == addr)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

[src/tdsu_ifs.sv]
// Valid/ready channel interfaces for input words and result items.
interface tdsu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic        first_word;
  logic        last_word;

  modport source(output valid, data_word, first_word, last_word, input ready);
  modport sink(input valid, data_word, first_word, last_word, output ready);
endinterface

interface tdsu_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [15:0] endpoint_address;
  logic [6:0]  channel;
  logic [7:0]  random_bits;
  logic [15:0] header_error_bits;
  logic        edge_res;
  logic [27:0] epoch;
  logic [10:0] coarse_time;
  logic [9:0]  fine_time;
  logic        is_reference;
  logic        bad_header_seen;
  logic        skip_overrun;

  modport source(output valid, item_kind, endpoint_address, channel, random_bits,
                 header_error_bits, edge_res, epoch, coarse_time, fine_time,
                 is_reference, bad_header_seen, skip_overrun, input ready);
  modport sink(input valid, item_kind, endpoint_address, channel, random_bits,
               header_error_bits, edge_res, epoch, coarse_time, fine_time,
               is_reference, bad_header_seen, skip_overrun, output ready);
endinterface

[src/tdsu_front.sv]
// Front end: accepts words, tracks block and payload state, builds queue entries.
module tdsu_front import tdsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  tdsu_cfg_t   cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic        q_full,
  output logic        q_push,
  output tdsu_entry_t q_entry
);

  logic [15:0] skip_r, skip_nxt;
  logic [15:0] pay_rem_r, pay_rem_nxt;
  logic [15:0] pay_len_r, pay_len_nxt;
  logic [15:0] cur_ep_r, cur_ep_nxt;
  logic [7:0]  rnd_r, rnd_nxt;
  logic [15:0] err_r, err_nxt;
  logic [27:0] epoch_r, epoch_nxt;
  logic        prev_valid_r, prev_valid_nxt;
  logic [6:0]  prev_ch_r, prev_ch_nxt;
  logic        bad_r, bad_nxt;

  logic        accept;
  logic        hit;
  logic [31:0] w;
  logic [6:0]  ch;
  logic        hub_match;
  logic        tdc_match;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign w        = in_data_word;
  assign ch       = w[28:22];

  assign hub_match = addr_in_list(cfg.hub_list, cfg.hub_count, w[15:0]);
  assign tdc_match = addr_in_list(cfg.tdc_list, cfg.tdc_count, w[15:0]);

  // Decode one word against the current block state
  always_comb begin
    skip_nxt       = skip_r;
    pay_rem_nxt    = pay_rem_r;
    pay_len_nxt    = pay_len_r;
    cur_ep_nxt     = cur_ep_r;
    rnd_nxt        = rnd_r;
    err_nxt        = err_r;
    epoch_nxt      = epoch_r;
    prev_valid_nxt = prev_valid_r;
    prev_ch_nxt    = prev_ch_r;
    bad_nxt        = bad_r;
    hit            = 1'b0;

    // First word of a subevent starts from a clean state
    if (in_first_word) begin
      skip_nxt       = '0;
      pay_rem_nxt    = '0;
      pay_len_nxt    = '0;
      cur_ep_nxt     = '0;
      rnd_nxt        = '0;
      err_nxt        = '0;
      epoch_nxt      = '0;
      prev_valid_nxt = 1'b0;
      prev_ch_nxt    = '0;
      bad_nxt        = 1'b0;
    end

    if (skip_nxt != 16'd0) begin
      skip_nxt = skip_nxt - 16'd1;
    end else if (pay_rem_nxt == 16'd0) begin
      // Address word: hub passes through, TDC opens a payload, others are skipped
      pay_len_nxt = w[31:16];
      if (hub_match) begin
        pay_len_nxt = w[31:16];
      end else if (tdc_match) begin
        pay_rem_nxt = w[31:16];
        cur_ep_nxt  = w[15:0];
      end else begin
        skip_nxt = w[31:16];
      end
    end else if (pay_rem_nxt == pay_len_nxt) begin
      // TDC header word
      rnd_nxt = '0;
      err_nxt = '0;
      if (w[31:29] != HEADER_MARK) begin
        bad_nxt     = 1'b1;
        skip_nxt    = pay_rem_nxt - 16'd1;
        pay_rem_nxt = '0;
      end else begin
        rnd_nxt        = w[23:16];
        err_nxt        = w[15:0];
        prev_valid_nxt = 1'b0;
        pay_rem_nxt    = pay_rem_nxt - 16'd1;
      end
    end else begin
      // Payload word: epoch, debug, time data or ignored
      if (w[31:29] == EPOCH_MARK) begin
        epoch_nxt      = w[27:0];
        prev_valid_nxt = 1'b0;
      end else if (w[31:29] == DEBUG_MARK) begin
        hit = 1'b0;
      end else if (w[31]) begin
        if (prev_valid_nxt && (ch != prev_ch_nxt)) epoch_nxt = '0;
        hit            = 1'b1;
        prev_valid_nxt = 1'b1;
        prev_ch_nxt    = ch;
      end
      pay_rem_nxt = pay_rem_nxt - 16'd1;
    end
  end

  // Build the queue entry
  always_comb begin
    q_entry                        = '0;
    q_entry.has_hit                = hit;
    q_entry.has_status             = in_last_word;
    q_entry.hit.item_kind          = KIND_HIT;
    q_entry.hit.endpoint_address   = cur_ep_nxt;
    q_entry.hit.channel            = ch;
    q_entry.hit.random_bits        = rnd_nxt;
    q_entry.hit.header_error_bits  = err_nxt;
    q_entry.hit.edge_res           = w[11];
    q_entry.hit.epoch              = epoch_nxt;
    q_entry.hit.coarse_time        = w[10:0];
    q_entry.hit.fine_time          = w[21:12];
    q_entry.hit.is_reference       = (ch == cfg.ref_channel);
    q_entry.bad_header_seen        = bad_nxt;
    q_entry.skip_overrun           = (skip_nxt != 16'd0);
  end

  assign q_push = accept && (hit || in_last_word);

  // Advance state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r       <= '0;
      pay_rem_r    <= '0;
      pay_len_r    <= '0;
      cur_ep_r     <= '0;
      rnd_r        <= '0;
      err_r        <= '0;
      epoch_r      <= '0;
      prev_valid_r <= 1'b0;
      prev_ch_r    <= '0;
      bad_r        <= 1'b0;
    end else if (accept) begin
      skip_r       <= skip_nxt;
      pay_rem_r    <= pay_rem_nxt;
      pay_len_r    <= pay_len_nxt;
      cur_ep_r     <= cur_ep_nxt;
      rnd_r        <= rnd_nxt;
      err_r        <= err_nxt;
      epoch_r      <= epoch_nxt;
      prev_valid_r <= prev_valid_nxt;
      prev_ch_r    <= prev_ch_nxt;
      bad_r        <= bad_nxt;
    end
  end

endmodule

[src/tdsu_queue.sv]
// Short queue of decoded words between front and back.
module tdsu_queue import tdsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  tdsu_entry_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output tdsu_entry_t head
);

  tdsu_entry_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_push;
  logic                do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (do_push && !do_pop)      count_r <= count_r + QCNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - QCNT_W'(1);
    end
  end

endmodule

[src/tdsu_back.sv]
// Back end: splits queue entries into hit and status results behind an output register.
module tdsu_back import tdsu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         head_valid,
  input  tdsu_entry_t  head,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output tdsu_result_t out_item
);

  logic         out_valid_r, out_valid_nxt;
  tdsu_result_t out_item_r, out_item_nxt;
  logic         phase_r, phase_nxt;
  logic         load;
  logic         two;
  tdsu_result_t status;

  assign load = !out_valid_r || out_ready;
  assign two  = head.has_hit && head.has_status;

  // Status request of the current entry
  always_comb begin
    status                 = '0;
    status.item_kind       = KIND_STATUS;
    status.bad_header_seen = head.bad_header_seen;
    status.skip_overrun    = head.skip_overrun;
  end

  // Hit goes first, status second when an entry carries both
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    phase_nxt     = phase_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        out_item_nxt = (head.has_hit && !phase_r) ? head.hit : status;
        pop          = !two || phase_r;
        phase_nxt    = two && !phase_r;
      end
    end
  end

  // Hold the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[src/tdc_subevent_word_unpacker_core.sv]
// Top level of the TDC subevent word unpacker: configuration registers and channels.
// Takes one subevent payload word per cycle while the queue has room and returns hit
// records and an end-of-subevent status over a valid/ready result channel. Each word
// is decoded in the cycle it is accepted; its results are registered in the queue and
// then in the output register. Results drain at one per cycle while the output is
// ready, so a word that yields both a hit and the status occupies the output with the
// hit and then the status; the four-entry queue between decoder and output register
// absorbs that and any output stall, and input ready drops only when the queue is full.
// Blocks at the CTS address are skipped like any unknown address, so a write to that
// register is taken and has no further effect. The user must write configuration through
// cfg_we, cfg_index and cfg_data only while no words are in flight; the block itself does not enforce it.
module tdc_subevent_word_unpacker_core import tdsu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tdsu_in_if.sink               in_chan,
  tdsu_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  tdsu_cfg_t    cfg_r;
  logic         q_full;
  logic         q_push;
  tdsu_entry_t  q_entry;
  logic         q_pop;
  logic         q_head_valid;
  tdsu_entry_t  q_head;
  tdsu_result_t out_item;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HUB_LIST:  cfg_r.hub_list    <= cfg_data;
        CFG_HUB_COUNT: cfg_r.hub_count   <= cfg_data[2:0];
        CFG_TDC_LIST:  cfg_r.tdc_list    <= cfg_data;
        CFG_TDC_COUNT: cfg_r.tdc_count   <= cfg_data[2:0];
        CFG_CTS_ADDR:  cfg_r.ref_channel <= cfg_r.ref_channel;
        CFG_REF_CHAN:  cfg_r.ref_channel <= cfg_data[6:0];
        default:       cfg_r             <= cfg_r;
      endcase
    end
  end

  tdsu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_chan.valid),
    .in_ready      (in_chan.ready),
    .in_data_word  (in_chan.data_word),
    .in_first_word (in_chan.first_word),
    .in_last_word  (in_chan.last_word),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  tdsu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  tdsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_item   (out_item)
  );

  // Drive result payload
  assign out_chan.item_kind         = out_item.item_kind;
  assign out_chan.endpoint_address  = out_item.endpoint_address;
  assign out_chan.channel           = out_item.channel;
  assign out_chan.random_bits       = out_item.random_bits;
  assign out_chan.header_error_bits = out_item.header_error_bits;
  assign out_chan.edge_res          = out_item.edge_res;
  assign out_chan.epoch             = out_item.epoch;
  assign out_chan.coarse_time       = out_item.coarse_time;
  assign out_chan.fine_time         = out_item.fine_time;
  assign out_chan.is_reference      = out_item.is_reference;
  assign out_chan.bad_header_seen   = out_item.bad_header_seen;
  assign out_chan.skip_overrun      = out_item.skip_overrun;

endmodule
